// ===== hw/rtl/bgs_pkg.sv =====
`timescale 1ns / 1ps
package bgs_pkg;

    localparam int MV_W      = 14;
    localparam int PCT_W     = 7;
    localparam int DIGIT_W   = 4;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TENTHS_W  = 7;
    localparam int NUM_W     = 21;
    localparam int QBITS     = PCT_W + 1;
    localparam int STEP_W    = 3;

    localparam logic [MV_W-1:0]    EMPTY_MV_RST = 14'd3100;
    localparam logic [MV_W-1:0]    FULL_MV_RST  = 14'd4000;
    localparam logic [CNT_W-1:0]   SETTLE_RST   = 8'd5;

    localparam logic [PCT_W-1:0]    PCT_UNKNOWN = 7'd101;
    localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0]    PCT_STEP    = 7'd5;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX  = 7'd99;
    localparam logic [DIGIT_W-1:0]  DIGIT_MAX   = 4'd9;

    // 5243 / 2^19 approximates 1/100 closely enough for a 14-bit voltage.
    localparam int                 TENTH_RECIP_W = 13;
    localparam logic [12:0]        TENTH_RECIP   = 13'd5243;
    localparam int                 TENTH_SHIFT   = 19;
    localparam int                 TENTH_PROD_W  = MV_W + TENTH_RECIP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_MV     = 2'd0,
        CFG_FULL_MV      = 2'd1,
        CFG_SETTLE_COUNT = 2'd2
    } bgs_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } bgs_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [MV_W-1:0]  span;
    } bgs_div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
        logic             over;
    } bgs_div_rsp_t;

    // Rounds a percent down to a multiple of five; 205 / 2^10 stands in for 1/5.
    function automatic logic [PCT_W-1:0] round5(input logic [PCT_W-1:0] p);
        logic [PCT_W+7:0] prod;
        logic [PCT_W-1:0] q;
        prod = {8'd0, p} * 15'd205;
        q = PCT_W'(prod >> 10);
        return PCT_W'({q, 2'b00} + {2'b00, q});
    endfunction

endpackage

// ===== hw/rtl/bgs_if.sv =====
`timescale 1ns / 1ps
interface bgs_sample_if;
    import bgs_pkg::*;

    logic            valid;
    logic            ready;
    logic            measured;
    logic [MV_W-1:0] voltage_mv;
    logic            on_battery;

    modport source (output valid, output measured, output voltage_mv, output on_battery,
                    input ready);
    modport sink (input valid, input measured, input voltage_mv, input on_battery,
                  output ready);
endinterface

interface bgs_result_if;
    import bgs_pkg::*;

    logic               valid;
    logic               ready;
    logic [PCT_W-1:0]   shown_percent;
    logic [PCT_W-1:0]   raw_percent;
    logic [DIGIT_W-1:0] volts_units;
    logic [DIGIT_W-1:0] volts_tenths;
    logic               settling;

    modport source (output valid, output shown_percent, output raw_percent,
                    output volts_units, output volts_tenths, output settling,
                    input ready);
    modport sink (input valid, input shown_percent, input raw_percent,
                  input volts_units, input volts_tenths, input settling,
                  output ready);
endinterface

// ===== hw/rtl/bgs_div.sv =====
`timescale 1ns / 1ps
module bgs_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgs_pkg::bgs_div_cmd_t cmd,
    output bgs_pkg::bgs_div_rsp_t rsp
);
    import bgs_pkg::*;

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [MV_W-1:0]   span_reg, span_next;
    logic [QBITS-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NUM_W:0]    trial;
    logic              fits;

    // One restoring step per cycle. The top quotient bit only flags that the
    // quotient is 128 or more, which the caller clamps anyway.
    always_comb
    begin
        trial     = (NUM_W+1)'(span_reg) << step_reg;
        fits      = ({1'b0, rem_reg} >= trial);
        rem_next  = rem_reg;
        span_next = span_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            rem_next  = cmd.num;
            span_next = cmd.span;
            quot_next = '0;
            step_next = STEP_W'(QBITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next           = NUM_W'({1'b0, rem_reg} - trial);
                quot_next[step_reg] = 1'b1;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        span_reg <= span_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg[PCT_W-1:0];
    assign rsp.over = quot_reg[QBITS-1];

endmodule

// ===== hw/rtl/battery_gauge_smoother.sv =====
// Battery gauge smoother.
// Requests come in on the sample channel: a measured flag, the battery voltage
// in millivolts and the on-battery flag. Each request gives exactly one result
// on the result channel: the held percent (101 while unknown), the raw percent,
// the volt and tenths digits and the settling flag.
// The configuration port writes empty_mv (index 0), full_mv (index 1) and
// settle_count (index 2) whenever cfg_we is high; write only while idle.
// One request is worked on at a time. The raw percent comes from a separate
// compare/subtract unit that gives one quotient bit per cycle.
// A request with a measurement in range passes through that unit; a clamped
// one skips it, and one without measurement goes straight to the result.
// sample.ready returns the cycle the result is loaded, so a new request is
// taken only after the last one is through.
// The result sits in an output register: a stalled receiver does not block
// the next request, but a finished request waits for the register to free.
// Reset sets the registers to 3100 mV, 4000 mV and 5, the held percent to
// unknown and clears the settle state; no result is pending after reset.
`timescale 1ns / 1ps
module battery_gauge_smoother
(
    input  logic                            clk,
    input  logic                            rst_n,
    bgs_sample_if.sink                      sample,
    bgs_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [bgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgs_pkg::MV_W-1:0]        cfg_data
);
    import bgs_pkg::*;

    bgs_state_t state_reg, state_next;

    logic [MV_W-1:0]     empty_reg;
    logic [MV_W-1:0]     full_reg;
    logic [CNT_W-1:0]    settle_cnt_reg;

    logic                meas_reg, meas_next;
    logic [MV_W-1:0]     mv_reg, mv_next;
    logic                batt_reg, batt_next;

    logic [PCT_W-1:0]    held_reg, held_next;
    logic [PCT_W-1:0]    raw_reg, raw_next;
    logic [TENTHS_W-1:0] tenths_reg, tenths_next;
    logic                settle_act_reg, settle_act_next;
    logic [CNT_W-1:0]    settle_left_reg, settle_left_next;
    logic [PCT_W-1:0]    peak_reg, peak_next;
    logic                was_batt_reg, was_batt_next;

    logic                out_valid_reg, out_valid_next;
    logic [PCT_W-1:0]    out_shown_reg, out_shown_next;
    logic [PCT_W-1:0]    out_raw_reg, out_raw_next;
    logic [DIGIT_W-1:0]  out_units_reg, out_units_next;
    logic [DIGIT_W-1:0]  out_tnth_reg, out_tnth_next;
    logic                out_settle_reg, out_settle_next;

    bgs_div_cmd_t        div_cmd;
    bgs_div_rsp_t        div_rsp;

    logic [TENTH_PROD_W-1:0] tenth_prod;
    logic [TENTHS_W:0]       tenth_raw;
    logic [MV_W-1:0]         diff_mv;
    logic [MV_W-1:0]         span_mv;
    logic [NUM_W-1:0]        num_calc;
    logic [CNT_W-1:0]        left_dec;
    logic [PCT_W-1:0]        peak_max;
    logic [PCT_W-1:0]        held_base;
    logic [TENTHS_W+7:0]     unit_prod;
    logic [DIGIT_W-1:0]      unit_digit;
    logic [DIGIT_W-1:0]      tenth_digit;
    logic                    out_free;

    bgs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg      <= EMPTY_MV_RST;
            full_reg       <= FULL_MV_RST;
            settle_cnt_reg <= SETTLE_RST;
        end
        else if (cfg_we)
        begin
            case (bgs_cfg_idx_t'(cfg_index))
                CFG_EMPTY_MV:     empty_reg      <= cfg_data;
                CFG_FULL_MV:      full_reg       <= cfg_data;
                CFG_SETTLE_COUNT: settle_cnt_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        tenth_prod  = MV_W'(mv_reg) * TENTH_PROD_W'(TENTH_RECIP);
        tenth_raw   = tenth_prod[TENTH_PROD_W-1:TENTH_SHIFT];
        diff_mv     = mv_reg - empty_reg;
        span_mv     = full_reg - empty_reg;
        num_calc    = (NUM_W'(diff_mv) << 6) + (NUM_W'(diff_mv) << 5)
                    + (NUM_W'(diff_mv) << 2);
        left_dec    = settle_left_reg - CNT_W'(1);
        peak_max    = (peak_reg < raw_reg) ? raw_reg : peak_reg;
        held_base   = (held_reg == PCT_UNKNOWN) ? round5(raw_reg) : held_reg;
        // 205 / 2^11 stands in for 1/10 on values up to 99.
        unit_prod   = {8'd0, tenths_reg} * 15'd205;
        unit_digit  = unit_prod[TENTHS_W+7:11];
        tenth_digit = DIGIT_W'(tenths_reg - TENTHS_W'({unit_digit, 3'b000})
                               - TENTHS_W'({unit_digit, 1'b0}));
        out_free    = !out_valid_reg || result.ready;

        state_next       = state_reg;
        meas_next        = meas_reg;
        mv_next          = mv_reg;
        batt_next        = batt_reg;
        held_next        = held_reg;
        raw_next         = raw_reg;
        tenths_next      = tenths_reg;
        settle_act_next  = settle_act_reg;
        settle_left_next = settle_left_reg;
        peak_next        = peak_reg;
        was_batt_next    = was_batt_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_shown_next   = out_shown_reg;
        out_raw_next     = out_raw_reg;
        out_units_next   = out_units_reg;
        out_tnth_next    = out_tnth_reg;
        out_settle_next  = out_settle_reg;
        div_cmd          = '0;
        sample.ready     = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    meas_next  = sample.measured;
                    mv_next    = sample.voltage_mv;
                    batt_next  = sample.on_battery;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (!meas_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    tenths_next = (tenth_raw > {1'b0, TENTHS_MAX}) ? TENTHS_MAX
                                                                   : tenth_raw[TENTHS_W-1:0];
                    if (full_reg <= empty_reg)
                    begin
                        raw_next   = (mv_reg > empty_reg) ? PCT_FULL : '0;
                        state_next = ST_UPDATE;
                    end
                    else if (mv_reg <= empty_reg)
                    begin
                        raw_next   = '0;
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        div_cmd.start = 1'b1;
                        div_cmd.num   = num_calc;
                        div_cmd.span  = span_mv;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    raw_next   = (div_rsp.over || div_rsp.quot > PCT_FULL) ? PCT_FULL
                                                                          : div_rsp.quot;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (settle_act_reg)
                begin
                    settle_left_next = left_dec;
                    peak_next        = peak_max;
                    if (left_dec == '0)
                    begin
                        settle_act_next = 1'b0;
                        held_next       = round5(peak_max);
                    end
                end
                else if (batt_reg)
                begin
                    held_next = (held_base > raw_reg && held_base > PCT_STEP)
                              ? held_base - PCT_STEP : held_base;
                end
                else
                begin
                    held_next = round5(raw_reg);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    // Unplug detection runs after the measurement, on every request.
                    if (batt_reg && !was_batt_reg)
                    begin
                        settle_act_next  = 1'b1;
                        settle_left_next = settle_cnt_reg;
                        peak_next        = '0;
                    end
                    was_batt_next   = batt_reg;
                    out_valid_next  = 1'b1;
                    out_shown_next  = held_reg;
                    out_raw_next    = raw_reg;
                    out_units_next  = unit_digit;
                    out_tnth_next   = tenth_digit;
                    out_settle_next = settle_act_reg || (batt_reg && !was_batt_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= PCT_UNKNOWN;
            raw_reg         <= '0;
            tenths_reg      <= '0;
            settle_act_reg  <= 1'b0;
            settle_left_reg <= '0;
            peak_reg        <= '0;
            was_batt_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            held_reg        <= held_next;
            raw_reg         <= raw_next;
            tenths_reg      <= tenths_next;
            settle_act_reg  <= settle_act_next;
            settle_left_reg <= settle_left_next;
            peak_reg        <= peak_next;
            was_batt_reg    <= was_batt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg       <= meas_next;
        mv_reg         <= mv_next;
        batt_reg       <= batt_next;
        out_shown_reg  <= out_shown_next;
        out_raw_reg    <= out_raw_next;
        out_units_reg  <= out_units_next;
        out_tnth_reg   <= out_tnth_next;
        out_settle_reg <= out_settle_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.shown_percent = out_shown_reg;
    assign result.raw_percent   = out_raw_reg;
    assign result.volts_units   = out_units_reg;
    assign result.volts_tenths  = out_tnth_reg;
    assign result.settling      = out_settle_reg;

endmodule

// ===== hw/rtl/bgs_checker.sv =====
`timescale 1ns / 1ps
module bgs_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         r_valid,
    input logic                         r_ready,
    input logic [bgs_pkg::PCT_W-1:0]    shown,
    input logic [bgs_pkg::PCT_W-1:0]    raw,
    input logic [bgs_pkg::DIGIT_W-1:0]  units,
    input logic [bgs_pkg::DIGIT_W-1:0]  tenths
);
    import bgs_pkg::*;

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready |=> !s_ready)
        else $error("sample accepted while a request is in progress");

    a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (shown == PCT_UNKNOWN) || (shown <= PCT_FULL && round5(shown) == shown))
        else $error("shown percent is neither unknown nor a multiple of five");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> raw <= PCT_FULL && units <= DIGIT_MAX && tenths <= DIGIT_MAX)
        else $error("raw percent or voltage digit out of range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(shown) && $stable(raw))
        else $error("stalled result changed");

endmodule

bind battery_gauge_smoother bgs_checker u_bgs_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample.valid),
    .s_ready (sample.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .shown   (result.shown_percent),
    .raw     (result.raw_percent),
    .units   (result.volts_units),
    .tenths  (result.volts_tenths)
);
